[sv/sqte_pkg.sv]
// Package for the SARSA Q-table engine: field widths, register map, operation
// codes, controller states and reset values of the configuration registers.
// Used by sarsa_q_table_engine; it depends on nothing else.
package sqte_pkg;

	// Widths of the item fields, fixed by the interface.
	localparam int unsigned OP_W    = 2;
	localparam int unsigned STATE_W = 8;
	localparam int unsigned ACT_W   = 4;
	localparam int unsigned VAL_W   = 32;
	localparam int unsigned DRAW_W  = 16;
	localparam int unsigned CFG_W   = 17;

	// Configuration port.
	localparam int unsigned PADDR_W = 4;
	localparam int unsigned PDATA_W = 32;

	// Register indexes, taken from paddr[3:2].
	localparam logic [1:0] REG_EPSILON = 2'd0;
	localparam logic [1:0] REG_ALPHA   = 2'd1;
	localparam logic [1:0] REG_GAMMA   = 2'd2;

	// Register reset values.
	localparam logic [CFG_W-1:0] EPSILON_RST = 17'd6554;
	localparam logic [CFG_W-1:0] ALPHA_RST   = 17'd6554;
	localparam logic [CFG_W-1:0] GAMMA_RST   = 17'd58982;

	// Default table geometry.
	localparam int unsigned NUM_STATES_DEF  = 256;
	localparam int unsigned NUM_ACTIONS_DEF = 16;

	// Datapath widths of the update arithmetic.
	localparam int unsigned FRAC_W = 16;
	localparam int unsigned PG_W   = VAL_W + CFG_W + 1;   // gamma * q_next
	localparam int unsigned DF_W   = VAL_W + 3;           // reward + disc - q
	localparam int unsigned PA_W   = DF_W + CFG_W + 1;    // alpha * diff
	localparam int unsigned NV_W   = PA_W - FRAC_W + 1;   // q + delta

	typedef enum logic [OP_W-1:0] {
		OP_CHOOSE = 2'd0,
		OP_UPDATE = 2'd1,
		OP_WRITE  = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_QN,
		ST_QC,
		ST_MG,
		ST_DF,
		ST_MA,
		ST_WB,
		ST_WR,
		ST_RD,
		ST_RDW,
		ST_DONE
	} fsm_t;

endpackage

[sv/sarsa_q_table_engine.sv]
// SARSA Q-table engine. The table holds NUM_STATES x NUM_ACTIONS signed Q16.16
// values in one RAM and is zeroed by a clearing pass after reset during which
// req_stall is high; configuration writes are taken as usual. Items are worked
// one at a time. A greedy choose scans the row one entry per RAM read; an
// exploring choose skips the scan. An update adds the fetch of q_next and q,
// two multiplies and the write-back, after a scan when greedy. Write and read
// each pass through their own states; the single RAM read port serialises the
// reads. A finished result sits in the output register, so a new item can be
// taken while it waits. Out-of-range state and action indexes wrap modulo
// NUM_STATES and NUM_ACTIONS respectively.
module sarsa_q_table_engine
	import sqte_pkg::*;
#(
	parameter int unsigned NUM_STATES  = NUM_STATES_DEF,
	parameter int unsigned NUM_ACTIONS = NUM_ACTIONS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// Configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	// Request channel
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [OP_W-1:0]    operation,
	input  logic [STATE_W-1:0] state,
	input  logic [ACT_W-1:0]   action,
	input  logic [STATE_W-1:0] dest_state,
	input  logic signed [VAL_W-1:0] reward,
	input  logic [DRAW_W-1:0]  explore_draw,
	input  logic [ACT_W-1:0]   random_action,
	input  logic signed [VAL_W-1:0] entry_value,
	// Response channel
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [ACT_W-1:0]   chosen_action,
	output logic signed [VAL_W-1:0] q_value,
	output logic               saturated
);

	localparam int unsigned DEPTH      = NUM_STATES * NUM_ACTIONS;
	localparam int unsigned AW         = $clog2(DEPTH);
	localparam int unsigned SROW_W     = $clog2(NUM_STATES);
	localparam int unsigned AC_W       = $clog2(NUM_ACTIONS);
	localparam int unsigned SC_W       = $clog2(NUM_ACTIONS + 1);
	localparam int unsigned STATE_SPAN = 2 ** STATE_W;
	localparam int unsigned ACT_SPAN   = 2 ** ACT_W;

	// Configuration registers
	logic [CFG_W-1:0] epsilon_q, alpha_q, gamma_q;
	logic             cfg_wr;

	// Controller
	fsm_t fsm_q, fsm_nxt;
	logic [AW-1:0] clr_cnt_q;
	logic [SC_W-1:0] scan_cnt_q;
	logic rsp_load;

	// Latched item
	op_t op_in, op_q;
	logic [AW-1:0] cur_addr_q, scan_base_q;
	logic signed [VAL_W-1:0] reward_q, entry_q;

	// Wrapped indexes and addresses of the incoming beat
	logic [SROW_W-1:0] smod_tab [STATE_SPAN];
	logic [AC_W-1:0]   amod_tab [ACT_SPAN];
	logic [AW-1:0]     cur_addr_in, srow_in, nrow_in;
	logic              explore_in;

	// Scan and arithmetic
	logic [AC_W-1:0] best_idx_q;
	logic signed [VAL_W-1:0] best_val_q, qnext_q, qcur_q;
	logic signed [PG_W-1:0]  prodg_q;
	logic signed [DF_W-1:0]  diff_q, diff_nxt;
	logic signed [PA_W-1:0]  proda_q;
	logic signed [NV_W-1:0]  nv;
	logic signed [VAL_W-1:0] nv_sat;
	logic                    nv_ovf;
	logic signed [VAL_W-1:0] res_qval_q;
	logic                    res_sat_q;

	// RAM ports
	logic              mem_we;
	logic [AW-1:0]     mem_waddr, mem_raddr, scan_addr;
	logic [VAL_W-1:0]  mem_wdata, mem_rdata;
	logic signed [VAL_W-1:0] rd_val;

	// Response registers
	logic              rsp_valid_q;
	logic [ACT_W-1:0]  rsp_act_q;
	logic signed [VAL_W-1:0] rsp_qval_q;
	logic              rsp_sat_q;

	// Modulo tables for wrapping state and action indexes.
	for (genvar g = 0; g < STATE_SPAN; g++) begin : g_smod
		localparam int unsigned SMOD = g % NUM_STATES;
		assign smod_tab[g] = SROW_W'(SMOD);
	end
	for (genvar g = 0; g < ACT_SPAN; g++) begin : g_amod
		localparam int unsigned AMOD = g % NUM_ACTIONS;
		assign amod_tab[g] = AC_W'(AMOD);
	end

	assign op_in       = op_t'(operation);
	assign srow_in     = AW'(smod_tab[state]) * AW'(NUM_ACTIONS);
	assign nrow_in     = AW'(smod_tab[dest_state]) * AW'(NUM_ACTIONS);
	assign cur_addr_in = srow_in + AW'(amod_tab[action]);
	assign explore_in  = ({1'b0, explore_draw} < epsilon_q);

	// Configuration writes and reads.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epsilon_q <= EPSILON_RST;
			alpha_q   <= ALPHA_RST;
			gamma_q   <= GAMMA_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_EPSILON: epsilon_q <= pwdata[CFG_W-1:0];
				REG_ALPHA:   alpha_q   <= pwdata[CFG_W-1:0];
				REG_GAMMA:   gamma_q   <= pwdata[CFG_W-1:0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_EPSILON: prdata = PDATA_W'(epsilon_q);
			REG_ALPHA:   prdata = PDATA_W'(alpha_q);
			REG_GAMMA:   prdata = PDATA_W'(gamma_q);
			default:     prdata = '0;
		endcase
	end

	// Q table storage.
	sqte_ram #(
		.WIDTH(VAL_W),
		.DEPTH(DEPTH)
	) u_qram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign rd_val = $signed(mem_rdata);

	// Row scan address; it parks at the row base after the last read.
	assign scan_addr = (scan_cnt_q < SC_W'(NUM_ACTIONS)) ?
		scan_base_q + AW'(scan_cnt_q) : scan_base_q;

	// Update arithmetic: floor shifts are arithmetic right shifts.
	assign diff_nxt = DF_W'(reward_q) + DF_W'($signed(prodg_q[PG_W-1:FRAC_W]))
		- DF_W'(qcur_q);
	assign nv = NV_W'(qcur_q) + NV_W'($signed(proda_q[PA_W-1:FRAC_W]));

	// Saturate to the signed 32-bit range.
	always_comb begin
		nv_ovf = !((&nv[NV_W-1:VAL_W-1]) || !(|nv[NV_W-1:VAL_W-1]));
		if (nv_ovf) begin
			nv_sat = nv[NV_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
		end else begin
			nv_sat = nv[VAL_W-1:0];
		end
	end

	// Controller state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q <= ST_CLEAR;
		end else begin
			fsm_q <= fsm_nxt;
		end
	end

	// Next state, RAM control and handshake.
	always_comb begin
		fsm_nxt   = fsm_q;
		req_stall = 1'b1;
		mem_we    = 1'b0;
		mem_waddr = cur_addr_q;
		mem_wdata = entry_q;
		mem_raddr = cur_addr_q;
		rsp_load  = 1'b0;
		case (fsm_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_cnt_q;
				mem_wdata = '0;
				if (clr_cnt_q == AW'(DEPTH - 1)) begin
					fsm_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					case (op_in)
						OP_CHOOSE: fsm_nxt = explore_in ? ST_DONE : ST_SCAN;
						OP_UPDATE: fsm_nxt = explore_in ? ST_QN : ST_SCAN;
						OP_WRITE:  fsm_nxt = ST_WR;
						OP_READ:   fsm_nxt = ST_RD;
						default:   fsm_nxt = ST_IDLE;
					endcase
				end
			end
			ST_SCAN: begin
				mem_raddr = scan_addr;
				if (scan_cnt_q == SC_W'(NUM_ACTIONS)) begin
					fsm_nxt = (op_q == OP_UPDATE) ? ST_QN : ST_DONE;
				end
			end
			ST_QN: begin
				mem_raddr = scan_base_q + AW'(best_idx_q);
				fsm_nxt   = ST_QC;
			end
			ST_QC: fsm_nxt = ST_MG;
			ST_MG: fsm_nxt = ST_DF;
			ST_DF: fsm_nxt = ST_MA;
			ST_MA: fsm_nxt = ST_WB;
			ST_WB: begin
				mem_we    = 1'b1;
				mem_wdata = nv_sat;
				fsm_nxt   = ST_DONE;
			end
			ST_WR: begin
				mem_we  = 1'b1;
				fsm_nxt = ST_DONE;
			end
			ST_RD:  fsm_nxt = ST_RDW;
			ST_RDW: fsm_nxt = ST_DONE;
			ST_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_load = 1'b1;
					fsm_nxt  = ST_IDLE;
				end
			end
			default: fsm_nxt = ST_IDLE;
		endcase
	end

	// Clearing pass and scan counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q  <= '0;
			scan_cnt_q <= '0;
		end else begin
			if (fsm_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
			if (fsm_q == ST_IDLE) begin
				scan_cnt_q <= '0;
			end else if (fsm_q == ST_SCAN) begin
				scan_cnt_q <= scan_cnt_q + SC_W'(1);
			end
		end
	end

	// Item capture, argmax tracking and update datapath.
	always_ff @(posedge clk) begin
		case (fsm_q)
			ST_IDLE: begin
				if (req_valid) begin
					op_q        <= op_in;
					cur_addr_q  <= cur_addr_in;
					scan_base_q <= (op_in == OP_UPDATE) ? nrow_in : srow_in;
					reward_q    <= reward;
					entry_q     <= entry_value;
					best_idx_q  <= amod_tab[random_action];
					res_qval_q  <= '0;
					res_sat_q   <= 1'b0;
				end
			end
			ST_SCAN: begin
				// Read data arrives in the cycle after its address; strict compare keeps
				// the lowest index on ties.
				if (scan_cnt_q != '0) begin
					if (scan_cnt_q == SC_W'(1) || rd_val > best_val_q) begin
						best_val_q <= rd_val;
						best_idx_q <= AC_W'(scan_cnt_q - SC_W'(1));
					end
				end
			end
			ST_QC: qnext_q <= rd_val;
			ST_MG: begin
				qcur_q  <= rd_val;
				prodg_q <= PG_W'($signed({1'b0, gamma_q})) * PG_W'(qnext_q);
			end
			ST_DF: diff_q <= diff_nxt;
			ST_MA: proda_q <= PA_W'(diff_q) * PA_W'($signed({1'b0, alpha_q}));
			ST_WB: begin
				res_qval_q <= nv_sat;
				res_sat_q  <= nv_ovf;
			end
			ST_WR:  res_qval_q <= entry_q;
			ST_RDW: res_qval_q <= rd_val;
			default: ;
		endcase
	end

	// Output register: holds a finished beat until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_act_q  <= (op_q == OP_CHOOSE || op_q == OP_UPDATE) ?
				ACT_W'(best_idx_q) : '0;
			rsp_qval_q <= res_qval_q;
			rsp_sat_q  <= res_sat_q;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign chosen_action = rsp_act_q;
	assign q_value       = rsp_qval_q;
	assign saturated     = rsp_sat_q;

	// The table is never written outside the clearing pass and write-back states.
	a_we_states: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (fsm_q == ST_CLEAR || fsm_q == ST_WR || fsm_q == ST_WB))
		else $error("table written outside a write state");

	// No result can appear before the clearing pass has finished.
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		fsm_q == ST_CLEAR |-> !rsp_valid_q)
		else $error("response during clearing pass");

	// Only one item is in flight: an accepted beat closes the request side.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second item accepted while busy");

	// The scan never runs past the last action of the row.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fsm_q == ST_SCAN |-> scan_cnt_q <= SC_W'(NUM_ACTIONS))
		else $error("row scan overran");

	// Saturation can only be reported for an update.
	a_sat_update: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load && res_sat_q |-> op_q == OP_UPDATE)
		else $error("saturation flagged on a non-update item");

endmodule

[sv/sqte_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered
// read data. No reset on the storage. No dependencies.
module sqte_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[sim/tb_sarsa_q_table_engine.sv]
`timescale 1ns / 100ps
// Self-checking testbench for sarsa_q_table_engine: directed and random request beats,
// a scoreboard class that predicts every response beat, and APB register setup.
// Depends on sqte_pkg and the sarsa_q_table_engine RTL only.
module tb_sarsa_q_table_engine;
	import sqte_pkg::*;

	localparam int unsigned NUM_STATES  = NUM_STATES_DEF;
	localparam int unsigned NUM_ACTIONS = NUM_ACTIONS_DEF;
	localparam logic [1:0]  REG_UNUSED  = 2'd3;
	localparam int          HOLD_CYCLES = 300;
	localparam int          IDLE_LIMIT  = 20000;
	localparam longint      Q_MAX       = 64'sd2147483647;
	localparam longint      Q_MIN       = -64'sd2147483648;

	typedef struct {
		op_t                op;
		logic [STATE_W-1:0] st;
		logic [ACT_W-1:0]   act;
		logic [STATE_W-1:0] nst;
		logic signed [31:0] rew;
		logic [DRAW_W-1:0]  draw;
		logic [ACT_W-1:0]   rnd;
		logic signed [31:0] val;
	} req_t;

	typedef struct {
		logic [ACT_W-1:0]   act;
		logic signed [31:0] qv;
		logic               sat;
	} rsp_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               req_valid;
	logic               req_stall;
	logic [OP_W-1:0]    operation;
	logic [STATE_W-1:0] state;
	logic [ACT_W-1:0]   action;
	logic [STATE_W-1:0] dest_state;
	logic signed [VAL_W-1:0] reward;
	logic [DRAW_W-1:0]  explore_draw;
	logic [ACT_W-1:0]   random_action;
	logic signed [VAL_W-1:0] entry_value;
	logic               rsp_valid;
	logic               rsp_stall;
	logic [ACT_W-1:0]   chosen_action;
	logic signed [VAL_W-1:0] q_value;
	logic               saturated;

	bit quiet;
	bit hold_req;

	// Shadow copy of the Q table and registers that predicts each response beat.
	class sarsa_scoreboard;
		logic signed [31:0] q_shadow [NUM_STATES*NUM_ACTIONS];
		logic [CFG_W-1:0]   eps;
		logic [CFG_W-1:0]   alp;
		logic [CFG_W-1:0]   gam;
		rsp_t               due_results [$];
		int                 errors;
		int                 n_checked;
		int                 n_explore;
		int                 n_sat;
		int                 n_op [4];

		function new();
			eps = EPSILON_RST;
			alp = ALPHA_RST;
			gam = GAMMA_RST;
			foreach (q_shadow[i]) q_shadow[i] = '0;
		endfunction

		// Epsilon-greedy pick; the lowest index wins a tie.
		function logic [ACT_W-1:0] greedy_or_explore(int row, logic [DRAW_W-1:0] draw,
				logic [ACT_W-1:0] rnd);
			int best;
			if ({1'b0, draw} < eps) begin
				n_explore++;
				return ACT_W'(rnd % NUM_ACTIONS);
			end
			best = 0;
			for (int a = 1; a < NUM_ACTIONS; a++) begin
				if (q_shadow[row*NUM_ACTIONS + a] > q_shadow[row*NUM_ACTIONS + best])
					best = a;
			end
			return best[ACT_W-1:0];
		endfunction

		function void note_request(req_t r);
			int               idx;
			int               nidx;
			int               nrow;
			logic [ACT_W-1:0] na;
			longint           qn;
			longint           qc;
			longint           g;
			longint           a;
			longint           rw;
			longint           disc;
			longint           diff;
			longint           delta;
			longint           nv;
			rsp_t             e;
			idx = (r.st % NUM_STATES) * NUM_ACTIONS + (r.act % NUM_ACTIONS);
			e.act = '0;
			e.qv = '0;
			e.sat = 1'b0;
			n_op[r.op]++;
			case (r.op)
				OP_CHOOSE: e.act = greedy_or_explore(r.st % NUM_STATES, r.draw, r.rnd);
				OP_UPDATE: begin
					nrow = r.nst % NUM_STATES;
					na = greedy_or_explore(nrow, r.draw, r.rnd);
					nidx = nrow * NUM_ACTIONS + na;
					qn = longint'(q_shadow[nidx]);
					qc = longint'(q_shadow[idx]);
					g = longint'(gam);
					a = longint'(alp);
					rw = longint'(r.rew);
					// Both products truncate toward minus infinity.
					disc = (qn * g) >>> FRAC_W;
					diff = rw + disc - qc;
					delta = (diff * a) >>> FRAC_W;
					nv = qc + delta;
					if (nv > Q_MAX) begin
						nv = Q_MAX;
						e.sat = 1'b1;
					end else if (nv < Q_MIN) begin
						nv = Q_MIN;
						e.sat = 1'b1;
					end
					n_sat += int'(e.sat);
					q_shadow[idx] = nv[31:0];
					e.act = na;
					e.qv = nv[31:0];
				end
				OP_WRITE: begin
					q_shadow[idx] = r.val;
					e.qv = r.val;
				end
				default: e.qv = q_shadow[idx];
			endcase
			due_results.push_back(e);
		endfunction

		function void check_response(logic [ACT_W-1:0] act, logic signed [31:0] qv,
				logic sat);
			rsp_t e;
			if (due_results.size() == 0) begin
				$error("response beat with no request outstanding");
				errors++;
				return;
			end
			e = due_results.pop_front();
			n_checked++;
			if (act !== e.act) begin
				$error("chosen_action: expected %0d, got %0d", e.act, act);
				errors++;
			end
			if (qv !== e.qv) begin
				$error("q_value: expected %0d (0x%08h), got %0d (0x%08h)",
					e.qv, e.qv, qv, qv);
				errors++;
			end
			if (sat !== e.sat) begin
				$error("saturated: expected %0d, got %0d", e.sat, sat);
				errors++;
			end
		endfunction

		function int pending();
			return due_results.size();
		endfunction
	endclass

	sarsa_scoreboard sb = new();

	sarsa_q_table_engine DUT (.*);

	always #2 clk = ~clk;

	// Every accepted beat on either channel goes to the scoreboard.
	always @(posedge clk) begin
		req_t r;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall)
				sb.check_response(chosen_action, q_value, saturated);
			if (req_valid && !req_stall) begin
				r.op = op_t'(operation);
				r.st = state;
				r.act = action;
				r.nst = dest_state;
				r.rew = reward;
				r.draw = explore_draw;
				r.rnd = random_action;
				r.val = entry_value;
				sb.note_request(r);
			end
		end
	end

	// Response back-pressure: random bursts, one long hold on request.
	initial begin
		wait (arst_n);
		forever begin
			if (hold_req) begin
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end else begin
				rsp_stall <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	end

	// Watchdog: ends the run when no beat moves for too long.
	initial begin
		int idle_cnt;
		idle_cnt = 0;
		while (idle_cnt < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cnt = 0;
			else
				idle_cnt++;
		end
		$display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
		$display("sarsa_q_table_engine: mismatch");
		$finish;
	end

	function automatic req_t mk(op_t op, int s, int a, int ns, logic [31:0] rew, int draw,
			int rnd, logic [31:0] val);
		req_t r;
		r.op = op;
		r.st = STATE_W'(s);
		r.act = ACT_W'(a);
		r.nst = STATE_W'(ns);
		r.rew = rew;
		r.draw = DRAW_W'(draw);
		r.rnd = ACT_W'(rnd);
		r.val = val;
		return r;
	endfunction

	// Q16.16 value with weight on small magnitudes and the two extremes.
	function automatic logic [31:0] rand_q16();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2, 3, 4, 5: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
			default: return $urandom;
		endcase
	endfunction

	// One request beat, held until accepted, then an optional gap.
	task automatic send_req(req_t r);
		req_valid <= 1'b1;
		operation <= r.op;
		state <= r.st;
		action <= r.act;
		dest_state <= r.nst;
		reward <= r.rew;
		explore_draw <= r.draw;
		random_action <= r.rnd;
		entry_value <= r.val;
		do @(posedge clk); while (req_stall);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// Stop offering beats until every predicted response has been checked.
	task automatic wait_results_done();
		req_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	// APB write: setup phase, access phase, then idle with psel low.
	task automatic apb_write(logic [1:0] idx, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_EPSILON: sb.eps = data[CFG_W-1:0];
			REG_ALPHA:   sb.alp = data[CFG_W-1:0];
			REG_GAMMA:   sb.gam = data[CFG_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_config(logic [31:0] e, logic [31:0] a, logic [31:0] g);
		apb_write(REG_EPSILON, e);
		apb_write(REG_ALPHA, a);
		apb_write(REG_GAMMA, g);
	endtask

	// Random beats; most states fall in a few hot rows so updates build on each other.
	task automatic run_phase(int n, bit with_hold);
		req_t r;
		int   k;
		for (int i = 0; i < n; i++) begin
			if (with_hold && i == 10)
				hold_req = 1'b1;
			k = $urandom_range(0, 99);
			r.op = (k < 30) ? OP_CHOOSE : (k < 65) ? OP_UPDATE : (k < 80) ? OP_WRITE : OP_READ;
			r.st = STATE_W'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 7) : $urandom);
			r.nst = STATE_W'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 7) : $urandom);
			r.act = ACT_W'($urandom);
			r.rew = rand_q16();
			r.val = rand_q16();
			r.draw = DRAW_W'($urandom);
			r.rnd = ACT_W'($urandom);
			send_req(r);
		end
		wait_results_done();
	endtask

	// Main sequence.
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_valid = 1'b0;
		operation = OP_CHOOSE;
		state = '0;
		action = '0;
		dest_state = '0;
		reward = '0;
		explore_draw = '0;
		random_action = '0;
		entry_value = '0;
		rsp_stall = 1'b0;
		quiet = 1'b0;
		hold_req = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed beats at the reset settings.
		send_req(mk(OP_READ,   0,  0,   0, 32'h0,         16'hFFFF, 0, 32'h0));
		send_req(mk(OP_CHOOSE, 0,  5,   0, 32'h0,         16'hFFFF, 3, 32'h0));
		// Draw just below and at epsilon.
		send_req(mk(OP_CHOOSE, 0,  0,   0, 32'h0,         6553,    15, 32'h0));
		send_req(mk(OP_CHOOSE, 0,  0,   0, 32'h0,         6554,    15, 32'h0));
		send_req(mk(OP_WRITE,  255, 15, 0, 32'h0,         0,        0, 32'h7FFF_FFFF));
		send_req(mk(OP_WRITE,  255, 0,  0, 32'h0,         0,        0, 32'h8000_0000));
		send_req(mk(OP_READ,   255, 15, 0, 32'h0,         0,        0, 32'h0));
		send_req(mk(OP_CHOOSE, 255, 0,  0, 32'h0,         16'hFFFF, 0, 32'h0));
		// Tie between two equal entries goes to the lower action.
		send_req(mk(OP_WRITE,  3,  7,   0, 32'h0,         0,        0, 32'h5));
		send_req(mk(OP_WRITE,  3,  9,   0, 32'h0,         0,        0, 32'h5));
		send_req(mk(OP_CHOOSE, 3,  0,   0, 32'h0,         16'hFFFF, 0, 32'h0));
		// Updates that clamp at the top and at the bottom of the range.
		send_req(mk(OP_UPDATE, 255, 15, 255, 32'h7FFF_FFFF, 16'hFFFF, 0, 32'h0));
		send_req(mk(OP_UPDATE, 255, 0,  255, 32'h8000_0000, 0,        0, 32'h0));
		send_req(mk(OP_UPDATE, 1,  2,   3, 32'h0001_0000, 16'hFFFF, 0, 32'h0));
		send_req(mk(OP_READ,   1,  2,   0, 32'h0,         0,        0, 32'h0));
		send_req(mk(OP_UPDATE, 4,  0,   4, 32'hFFFF_0000, 16'hFFFF, 0, 32'h0));
		send_req(mk(OP_UPDATE, 3,  9, 255, 32'h0,         16'hFFFF, 0, 32'h0));
		send_req(mk(OP_READ,   3,  9,   0, 32'h0,         0,        0, 32'h0));
		send_req(mk(OP_CHOOSE, 255, 0,  0, 32'h0,         0,       10, 32'h0));
		wait_results_done();

		// Random phases over several register settings.
		run_phase(350, 1'b1);
		set_config(32'd0, 32'd65536, 32'd65536);
		run_phase(300, 1'b0);
		set_config(32'd65536, 32'd0, 32'd0);
		apb_write(REG_UNUSED, 32'h0);
		run_phase(200, 1'b0);
		set_config(32'h0001_FFFF, 32'h0001_FFFF, 32'h0001_FFFF);
		run_phase(200, 1'b0);
		set_config($urandom, $urandom, $urandom);
		run_phase(300, 1'b0);
		set_config($urandom_range(0, 65535), $urandom_range(0, 65536), $urandom);
		quiet = 1'b1;
		run_phase(300, 1'b0);

		repeat (40) @(posedge clk);
		$display("checked %0d responses: %0d choose, %0d update, %0d write, %0d read",
			sb.n_checked, sb.n_op[OP_CHOOSE], sb.n_op[OP_UPDATE], sb.n_op[OP_WRITE],
			sb.n_op[OP_READ]);
		$display("%0d exploring picks, %0d clamped updates, %0d field errors",
			sb.n_explore, sb.n_sat, sb.errors);
		if (sb.errors == 0)
			$display("sarsa_q_table_engine: match");
		else
			$display("sarsa_q_table_engine: mismatch");
		$finish;
	end

endmodule
